FILE: rtl/core/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
// list size, operation and status codes, transaction payloads, and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 5;
   localparam int POS_W    = 5;
   localparam int VAL_W    = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]              func;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [1:0]              status;
      logic [CNT_W-1:0]        count;
      logic                    is_empty;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load_rsp;
      logic       do_insert;
      logic       do_delete;
      logic       do_read;
      logic [1:0] status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pos_le_fill;
      logic pos_lt_fill;
      logic is_full;
   } dp_status_type;

endpackage

FILE: rtl/core/pls_ctrl.sv
// ----------------------------------------------------------------------------
// pls_ctrl: controller of the positional list store
// decodes the operation, checks range and full status, tracks the result slot
// ----------------------------------------------------------------------------
module pls_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_func,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  pls_pkg::dp_status_type dp_status,
   output pls_pkg::cmd_type      cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_HOLD = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign req_stall = (state_ff == S_HOLD) && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_HOLD);

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = S_HOLD;
      end else if ((state_ff == S_HOLD) && !rsp_stall) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.load_rsp  = accept;
      cmd.status    = pls_pkg::ST_OK;
      case (req_func)
         pls_pkg::OP_INSERT: begin
            if (!dp_status.pos_le_fill) begin
               cmd.status = pls_pkg::ST_RANGE;
            end else if (dp_status.is_full) begin
               cmd.status = pls_pkg::ST_FULL;
            end else begin
               cmd.do_insert = accept;
            end
         end
         pls_pkg::OP_DELETE: begin
            if (!dp_status.pos_lt_fill) begin
               cmd.status = pls_pkg::ST_RANGE;
            end else begin
               cmd.do_delete = accept;
            end
         end
         pls_pkg::OP_READ: begin
            if (!dp_status.pos_lt_fill) begin
               cmd.status = pls_pkg::ST_RANGE;
            end else begin
               cmd.do_read = accept;
            end
         end
         default: begin
            cmd.status = pls_pkg::ST_OK;
         end
      endcase
   end

endmodule

FILE: rtl/core/pls_dpath.sv
// ----------------------------------------------------------------------------
// pls_dpath: datapath of the positional list store
// slot registers with per-slot shift muxes, fill count and result register
// ----------------------------------------------------------------------------
module pls_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pls_pkg::POS_W-1:0]     position,
   input  logic signed [pls_pkg::VAL_W-1:0] new_value,
   input  pls_pkg::cmd_type              cmd,
   output pls_pkg::dp_status_type        dp_status,
   output pls_pkg::rsp_type              rsp_payload
);

   logic [pls_pkg::VAL_W-1:0] slots_ff [pls_pkg::CAPACITY];
   logic [pls_pkg::VAL_W-1:0] slots_in [pls_pkg::CAPACITY];
   logic [pls_pkg::CNT_W-1:0] fill_ff;
   logic [pls_pkg::CNT_W-1:0] fill_in;
   pls_pkg::rsp_type          rsp_ff;
   pls_pkg::rsp_type          rsp_in;
   logic [pls_pkg::VAL_W-1:0] rd_value;

   assign dp_status.pos_le_fill = (position <= fill_ff);
   assign dp_status.pos_lt_fill = (position < fill_ff);
   assign dp_status.is_full     = (fill_ff == pls_pkg::CNT_W'(pls_pkg::CAPACITY));

   // position is below fill here, so the low bits address the slot
   assign rd_value = cmd.do_read ? slots_ff[position[pls_pkg::IDX_W-1:0]] : '0;

   always_comb begin
      for (int i = 0; i < pls_pkg::CAPACITY; i++) begin
         slots_in[i] = slots_ff[i];
         if (cmd.do_insert) begin
            if (pls_pkg::POS_W'(i) == position) begin
               slots_in[i] = new_value;
            end else if ((pls_pkg::POS_W'(i) > position) && (i > 0)) begin
               slots_in[i] = slots_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (cmd.do_delete) begin
            if ((pls_pkg::POS_W'(i) >= position) && (i < pls_pkg::CAPACITY - 1)) begin
               slots_in[i] = slots_ff[(i < pls_pkg::CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.do_insert) begin
         fill_in = fill_ff + pls_pkg::CNT_W'(1);
      end else if (cmd.do_delete) begin
         fill_in = fill_ff - pls_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in            = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.read_value = rd_value;
         rsp_in.status     = cmd.status;
         rsp_in.count      = fill_in;
         rsp_in.is_empty   = (fill_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/core/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store: ordered list with insert, delete and read by position
// keeps up to CAPACITY signed 32-bit entries, one result per request
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_payload (func, position, new_value)
//   rsp       out         rsp_valid / rsp_stall  rsp_payload (read_value, status, count, is_empty)
//
// one transaction per cycle unless a result waits behind rsp_stall: the whole list shifts through
// per-slot muxes in the accepting cycle and the result shows in the next cycle from a register
// a new request is taken while the result register is emptied in that cycle
// req_stall is high only while a result waits and rsp_stall holds it
// reset clears the fill count and the result slot; slot contents need none
//
module positional_list_store (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pls_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pls_pkg::rsp_type  rsp_payload
);

   // command and status between the two halves
   pls_pkg::cmd_type      cmd;
   pls_pkg::dp_status_type dp_status;

   // controller: operation decode, error codes, result slot tracking
   pls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_payload.func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // datapath: slots, fill count and the result register
   pls_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .position    (req_payload.position),
      .new_value   (req_payload.new_value),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .rsp_payload (rsp_payload)
   );

   // the count never passes the list size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.count <= pls_pkg::CNT_W'(pls_pkg::CAPACITY)))
      else $error("count beyond capacity");

   // empty flag follows the count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.is_empty == (rsp_payload.count == '0)))
      else $error("empty flag disagrees with count");

   // a failed request returns no data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status != pls_pkg::ST_OK)) |-> (rsp_payload.read_value == '0))
      else $error("read value on an error result");

   // an accepted request always shows a result in the next cycle
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request without result");

   // the input stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with no result waiting");

endmodule
